@@ hw/rtl/i2cm_pkg.sv @@
// Shared types and constants for the I2C master byte engine.
// No dependencies; the top, front and back RTL files import this package.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // Byte framing
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE) + 1;

    // Register file
    localparam int TICKS_W     = 10;
    localparam int TIMEOUT_W   = 8;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_US = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT  = 1'd1;
    localparam logic [TICKS_W-1:0]     TICKS_RESET      = 10'd50;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET    = 8'd250;

    // Bus delay counter: up to 4 us of ticks
    localparam int DELAY_W = 12;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_STOP     = 3'd1,
        MODE_WRITE    = 3'd2,
        MODE_READ     = 3'd3,
        MODE_WAIT_ACK = 3'd4
    } mode_t;

    // Engine phases
    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_W_LOW, PH_W_HIGH,
        PH_W_TAIL, PH_R_LOW, PH_R_SAMPLE, PH_R_HIGH, PH_A_LOW, PH_A_HIGH,
        PH_WA_REL, PH_WA_RISE, PH_WA_POLL
    } phase_t;

    // One classified tick as it sits in the queue
    typedef struct packed {
        logic       cmd_ok;
        mode_t      mode;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_level;
    } tick_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2cm_ifs.sv @@
// Channel interfaces: tick beats in, line/status beats out.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_level;

    modport source (output valid, cmd_valid, mode, write_data, send_ack, sda_level,
                    input ready);
    modport sink   (input valid, cmd_valid, mode, write_data, send_ack, sda_level,
                    output ready);
endinterface

interface i2cm_line_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       ack_failed;

    modport source (output valid, scl_out, sda_out, sda_enable, busy_res, done_res,
                    read_value, ack_failed, input ready);
    modport sink   (input valid, scl_out, sda_out, sda_enable, busy_res, done_res,
                    read_value, ack_failed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: front queue plus bus sequencer.
// Depends on i2cm_pkg, i2cm_ifs, i2cm_front and i2cm_back.
//
//  Channel   Dir   Handshake          Beat contents
//  tick      in    valid/ready        cmd_valid, mode, write_data, send_ack, sda_level
//  line      out   valid/ready        scl_out, sda_out, sda_enable, busy_res,
//                                     done_res, read_value, ack_failed
//  cfg       in    cfg_write only     cfg_index, cfg_data
//
// One tick beat is taken per cycle while the queue has room and gives one line
// beat; the beat passes the two-entry queue and then the sequencer's registers,
// which are also the output register.
// Reset clears the queue and puts the bus at idle: SCL and SDA driven high.
// A stall on line backs up into the queue; tick ready drops when it is full.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data,
    i2cm_tick_if.sink                              tick,
    i2cm_line_if.source                            line
);
    import i2cm_pkg::*;

    tick_entry_t q_entry;
    logic        q_valid;
    logic        q_pop;

    // Classify and queue
    i2cm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .q_entry (q_entry),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // Sequence the bus
    i2cm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_entry   (q_entry),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .line      (line)
    );

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_front.sv @@
// Front end: takes tick beats, classifies the command and queues them.
// Depends on i2cm_pkg and i2cm_tick_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    i2cm_tick_if.sink                 tick,
    output i2cm_pkg::tick_entry_t     q_entry,
    output logic                      q_valid,
    input  wire logic                 q_pop
);
    import i2cm_pkg::*;

    tick_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    tick_entry_t         classified;

    // Classify: only known modes with cmd_valid count as a command
    always_comb
    begin
        classified.cmd_ok     = tick.cmd_valid && (tick.mode <= MODE_WAIT_ACK);
        classified.mode       = mode_t'(tick.mode);
        classified.write_data = tick.write_data;
        classified.send_ack   = tick.send_ack;
        classified.sda_level  = tick.sda_level;
    end

    assign tick.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = tick.valid && tick.ready;
    assign q_valid    = (count_reg != '0);
    assign q_entry    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= classified;
        end
    end

    // A pop never comes from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    // Fill count rises by one on a push without a pop
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_back.sv @@
// Back end: bus phase sequencer, config registers and output beat register.
// Depends on i2cm_pkg and i2cm_line_if.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire i2cm_pkg::tick_entry_t             q_entry,
    input  wire logic                              q_valid,
    output logic                                   q_pop,
    i2cm_line_if.source                            line
);
    import i2cm_pkg::*;

    // Config
    logic [TICKS_W-1:0]   ticks_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Engine state
    phase_t               phase_reg, phase_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [7:0]           tx_reg, tx_next;
    logic [7:0]           rx_reg, rx_next;
    logic [7:0]           wait_reg, wait_next;
    logic                 scl_reg, scl_next;
    logic                 sda_lvl_reg, sda_lvl_next;
    logic                 sda_en_reg, sda_en_next;
    logic                 ack_reg, ack_next;
    logic                 fail_reg, fail_next;
    logic                 done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;

    // Helpers
    logic [TICKS_W-1:0]   ticks_eff;
    logic [DELAY_W-1:0]   dly_1us, dly_2us, dly_4us;
    logic                 delay_live;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic                 last_bit;
    logic                 timeout_hit;

    assign ticks_eff   = (ticks_reg == '0) ? TICKS_W'(1) : ticks_reg;
    assign dly_1us     = DELAY_W'(ticks_eff);
    assign dly_2us     = DELAY_W'({ticks_eff, 1'b0});
    assign dly_4us     = DELAY_W'({ticks_eff, 2'b00});
    assign delay_live  = (delay_reg > DELAY_W'(1));
    assign bit_inc     = bit_reg + BIT_IDX_W'(1);
    assign last_bit    = (bit_inc >= BIT_IDX_W'(BITS_PER_BYTE));
    assign timeout_hit = (wait_reg >= timeout_reg);

    // Output register frees up when empty or being taken
    assign q_pop = q_valid && (!out_valid_reg || line.ready);

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg   <= TICKS_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TICKS_PER_US: ticks_reg   <= cfg_data[TICKS_W-1:0];
                CFG_ACK_TIMEOUT:  timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (q_entry.cmd_ok)
                    begin
                        unique case (q_entry.mode)
                            MODE_START:    phase_next = PH_ST_A;
                            MODE_STOP:     phase_next = PH_SP_A;
                            MODE_WRITE:    phase_next = PH_W_LOW;
                            MODE_READ:     phase_next = PH_R_LOW;
                            MODE_WAIT_ACK: phase_next = PH_WA_REL;
                            default:       phase_next = PH_IDLE;
                        endcase
                    end
                end
                PH_R_SAMPLE: phase_next = PH_R_HIGH;
                PH_WA_POLL:
                begin
                    if (!q_entry.sda_level)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (timeout_hit)
                    begin
                        phase_next = PH_SP_A;
                    end
                end
                default:
                begin
                    if (!delay_live)
                    begin
                        unique case (phase_reg)
                            PH_ST_A:    phase_next = PH_ST_B;
                            PH_SP_A:    phase_next = PH_SP_B;
                            PH_W_LOW:   phase_next = PH_W_HIGH;
                            PH_W_HIGH:  phase_next = PH_W_TAIL;
                            PH_W_TAIL:  phase_next = last_bit ? PH_IDLE : PH_W_LOW;
                            PH_R_LOW:   phase_next = PH_R_SAMPLE;
                            PH_R_HIGH:  phase_next = last_bit ? PH_A_LOW : PH_R_LOW;
                            PH_A_LOW:   phase_next = PH_A_HIGH;
                            PH_WA_REL:  phase_next = PH_WA_RISE;
                            PH_WA_RISE: phase_next = PH_WA_POLL;
                            default:    phase_next = PH_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    // Line drive, counters and shift registers
    always_comb
    begin
        delay_next   = delay_reg;
        bit_next     = bit_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        wait_next    = wait_reg;
        scl_next     = scl_reg;
        sda_lvl_next = sda_lvl_reg;
        sda_en_next  = sda_en_reg;
        ack_next     = ack_reg;
        fail_next    = fail_reg;
        done_next    = done_reg;
        if (q_pop)
        begin
            done_next = 1'b0;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (q_entry.cmd_ok)
                    begin
                        unique case (q_entry.mode)
                            MODE_START:
                            begin
                                sda_en_next  = 1'b1;
                                sda_lvl_next = 1'b1;
                                scl_next     = 1'b1;
                                delay_next   = dly_4us;
                            end
                            MODE_STOP:
                            begin
                                scl_next     = 1'b0;
                                sda_lvl_next = 1'b0;
                                sda_en_next  = 1'b1;
                                delay_next   = dly_4us;
                            end
                            MODE_WRITE:
                            begin
                                sda_en_next  = 1'b1;
                                scl_next     = 1'b0;
                                bit_next     = '0;
                                sda_lvl_next = q_entry.write_data[7];
                                tx_next      = {q_entry.write_data[6:0], 1'b0};
                                delay_next   = dly_2us;
                            end
                            MODE_READ:
                            begin
                                sda_en_next = 1'b0;
                                scl_next    = 1'b0;
                                bit_next    = '0;
                                rx_next     = '0;
                                ack_next    = q_entry.send_ack;
                                delay_next  = dly_2us;
                            end
                            MODE_WAIT_ACK:
                            begin
                                fail_next    = 1'b0;
                                sda_en_next  = 1'b0;
                                sda_lvl_next = 1'b1;
                                delay_next   = dly_1us;
                            end
                            default: ;
                        endcase
                    end
                end
                // Sample SDA one tick after SCL rose
                PH_R_SAMPLE:
                begin
                    rx_next    = {rx_reg[6:0], q_entry.sda_level};
                    delay_next = dly_1us;
                end
                // ACK poll: low SDA ends, timeout turns into a stop
                PH_WA_POLL:
                begin
                    if (!q_entry.sda_level)
                    begin
                        scl_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else if (timeout_hit)
                    begin
                        fail_next    = 1'b1;
                        scl_next     = 1'b0;
                        sda_lvl_next = 1'b0;
                        sda_en_next  = 1'b1;
                        delay_next   = dly_4us;
                    end
                    else
                    begin
                        wait_next = wait_reg + 8'd1;
                    end
                end
                default:
                begin
                    if (delay_live)
                    begin
                        delay_next = delay_reg - DELAY_W'(1);
                    end
                    else
                    begin
                        // Timed phase expired
                        case (phase_reg)
                            PH_ST_A:
                            begin
                                sda_lvl_next = 1'b0;
                                delay_next   = dly_4us;
                            end
                            PH_ST_B:
                            begin
                                scl_next  = 1'b0;
                                done_next = 1'b1;
                            end
                            PH_SP_A:
                            begin
                                scl_next     = 1'b1;
                                sda_lvl_next = 1'b1;
                                delay_next   = dly_4us;
                            end
                            PH_SP_B: done_next = 1'b1;
                            PH_W_LOW, PH_A_LOW:
                            begin
                                scl_next   = 1'b1;
                                delay_next = dly_2us;
                            end
                            PH_W_HIGH:
                            begin
                                scl_next   = 1'b0;
                                delay_next = dly_2us;
                            end
                            PH_W_TAIL:
                            begin
                                bit_next = bit_inc;
                                if (last_bit)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    sda_lvl_next = tx_reg[7];
                                    tx_next      = {tx_reg[6:0], 1'b0};
                                    delay_next   = dly_2us;
                                end
                            end
                            PH_R_LOW: scl_next = 1'b1;
                            PH_R_HIGH:
                            begin
                                bit_next   = bit_inc;
                                scl_next   = 1'b0;
                                delay_next = dly_2us;
                                if (last_bit)
                                begin
                                    sda_en_next  = 1'b1;
                                    sda_lvl_next = !ack_reg;
                                end
                            end
                            PH_A_HIGH:
                            begin
                                scl_next  = 1'b0;
                                done_next = 1'b1;
                            end
                            PH_WA_REL:
                            begin
                                scl_next   = 1'b1;
                                delay_next = dly_1us;
                            end
                            PH_WA_RISE: wait_next = '0;
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    // Output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (line.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            delay_reg     <= '0;
            bit_reg       <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            wait_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_lvl_reg   <= 1'b1;
            sda_en_reg    <= 1'b1;
            ack_reg       <= 1'b0;
            fail_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            delay_reg     <= delay_next;
            bit_reg       <= bit_next;
            tx_reg        <= tx_next;
            rx_reg        <= rx_next;
            wait_reg      <= wait_next;
            scl_reg       <= scl_next;
            sda_lvl_reg   <= sda_lvl_next;
            sda_en_reg    <= sda_en_next;
            ack_reg       <= ack_next;
            fail_reg      <= fail_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The engine state doubles as the output beat; it holds while stalled
    assign line.valid      = out_valid_reg;
    assign line.scl_out    = scl_reg;
    assign line.sda_out    = sda_lvl_reg;
    assign line.sda_enable = sda_en_reg;
    assign line.busy_res   = (phase_reg != PH_IDLE);
    assign line.done_res   = done_reg;
    assign line.read_value = rx_reg;
    assign line.ack_failed = fail_reg;

    // A done pulse always lands back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> phase_reg == PH_IDLE)
        else $error("done raised outside idle");

    // Bit counter never runs past one byte
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BIT_IDX_W'(BITS_PER_BYTE))
        else $error("bit index overrun");

    // A sampled read bit is always followed by the SCL-high hold
    a_sample_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && phase_reg == PH_R_SAMPLE) |=> phase_reg == PH_R_HIGH && scl_reg)
        else $error("read sample not followed by high hold");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for i2c_master_byte_engine: tick beats in, line beats checked.
// Depends on i2cm_pkg and the channel interfaces in i2cm_ifs; predicts every line beat.
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    // One tick beat and one line beat as the bench sees them
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_level;
    } tick_beat_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       ack_failed;
    } line_beat_t;

    typedef enum {SDA_NOISE, SDA_LOW_AFTER} sda_style_t;

    // Bus sequencer predictor plus the queue of line beats it owes
    class line_scoreboard;
        typedef enum logic [3:0] {
            S_IDLE, S_START_HOLD, S_START_LOW, S_STOP_LOW, S_STOP_HIGH,
            S_WR_SETUP, S_WR_HIGH, S_WR_HOLD, S_RD_LOW, S_RD_SAMPLE, S_RD_HIGH,
            S_ACK_LOW, S_ACK_HIGH, S_WA_RELEASE, S_WA_RISE, S_WA_POLL
        } seq_state_t;

        seq_state_t  st;
        logic [9:0]  tick_per_us;
        logic [7:0]  ack_limit;
        logic [11:0] delay_left;
        logic [3:0]  bit_cnt;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte;
        logic [7:0]  poll_cnt;
        logic        scl;
        logic        sda_lvl;
        logic        sda_en;
        logic [2:0]  cur_mode;
        logic        ack_bit;
        logic        ack_fail;
        line_beat_t  want_lines[$];
        int          errors;

        function new();
            tick_per_us = TICKS_RESET;
            ack_limit   = TIMEOUT_RESET;
            st          = S_IDLE;
            delay_left  = '0;
            bit_cnt     = '0;
            tx_byte     = '0;
            rx_byte     = '0;
            poll_cnt    = '0;
            scl         = 1'b1;
            sda_lvl     = 1'b1;
            sda_en      = 1'b1;
            cur_mode    = '0;
            ack_bit     = 1'b0;
            ack_fail    = 1'b0;
            errors      = 0;
        endfunction

        function void set_config(logic [9:0] t, logic [7:0] lim);
            tick_per_us = t;
            ack_limit   = lim;
        endfunction

        function bit engine_idle();
            return st == S_IDLE;
        endfunction

        function int outstanding();
            return want_lines.size();
        endfunction

        // zero ticks per microsecond counts as one; count wraps at 12 bits
        function void load_delay(int us);
            int t;
            t = (tick_per_us == 0) ? 1 : int'(tick_per_us);
            delay_left = 12'(us * t);
        endfunction

        function void shift_out();
            sda_lvl = tx_byte[7];
            tx_byte = {tx_byte[6:0], 1'b0};
        endfunction

        function void enter_stop();
            scl = 1'b0; sda_lvl = 1'b0; sda_en = 1'b1;
            load_delay(4);
            st = S_STOP_LOW;
        endfunction

        // advance one tick and queue the line beat it produces
        function void note_tick(tick_beat_t b);
            bit         fin;
            line_beat_t r;
            fin = 1'b0;
            if (st == S_IDLE)
            begin
                // commands only land while idle; modes past wait-ack are dropped
                if (b.cmd_valid && b.mode <= MODE_WAIT_ACK)
                begin
                    cur_mode = b.mode;
                    case (b.mode)
                        MODE_START:
                        begin
                            sda_en = 1'b1; sda_lvl = 1'b1; scl = 1'b1;
                            load_delay(4);
                            st = S_START_HOLD;
                        end
                        MODE_STOP:
                            enter_stop();
                        MODE_WRITE:
                        begin
                            sda_en = 1'b1; scl = 1'b0; bit_cnt = '0;
                            tx_byte = b.write_data;
                            shift_out();
                            load_delay(2);
                            st = S_WR_SETUP;
                        end
                        MODE_READ:
                        begin
                            sda_en = 1'b0; scl = 1'b0; bit_cnt = '0; rx_byte = '0;
                            ack_bit = b.send_ack;
                            load_delay(2);
                            st = S_RD_LOW;
                        end
                        default:
                        begin
                            ack_fail = 1'b0; sda_en = 1'b0; sda_lvl = 1'b1;
                            load_delay(1);
                            st = S_WA_RELEASE;
                        end
                    endcase
                end
            end
            else if (st == S_RD_SAMPLE)
            begin
                rx_byte = {rx_byte[6:0], b.sda_level};
                load_delay(1);
                st = S_RD_HIGH;
            end
            else if (st == S_WA_POLL)
            begin
                // low SDA is the ACK; too many high samples force a stop
                if (!b.sda_level)
                begin
                    scl = 1'b0; st = S_IDLE; fin = 1'b1;
                end
                else if (poll_cnt >= ack_limit)
                begin
                    ack_fail = 1'b1;
                    enter_stop();
                end
                else
                begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end
            else if (delay_left > 1)
            begin
                delay_left = delay_left - 12'd1;
            end
            else
            begin
                // timed phase expired
                case (st)
                    S_START_HOLD:
                    begin
                        sda_lvl = 1'b0; load_delay(4); st = S_START_LOW;
                    end
                    S_START_LOW:
                    begin
                        scl = 1'b0; st = S_IDLE; fin = 1'b1;
                    end
                    S_STOP_LOW:
                    begin
                        scl = 1'b1; sda_lvl = 1'b1;
                        load_delay(4);
                        st = S_STOP_HIGH;
                    end
                    S_STOP_HIGH:
                    begin
                        st = S_IDLE; fin = 1'b1;
                    end
                    S_WR_SETUP:
                    begin
                        scl = 1'b1; load_delay(2); st = S_WR_HIGH;
                    end
                    S_WR_HIGH:
                    begin
                        scl = 1'b0; load_delay(2); st = S_WR_HOLD;
                    end
                    S_WR_HOLD:
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE)
                        begin
                            st = S_IDLE; fin = 1'b1;
                        end
                        else
                        begin
                            shift_out();
                            load_delay(2);
                            st = S_WR_SETUP;
                        end
                    end
                    S_RD_LOW:
                    begin
                        scl = 1'b1; st = S_RD_SAMPLE;
                    end
                    S_RD_HIGH:
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        scl = 1'b0;
                        if (bit_cnt < BITS_PER_BYTE)
                        begin
                            load_delay(2);
                            st = S_RD_LOW;
                        end
                        else
                        begin
                            // ACK drives low, NACK leaves SDA high
                            sda_en = 1'b1; sda_lvl = !ack_bit;
                            load_delay(2);
                            st = S_ACK_LOW;
                        end
                    end
                    S_ACK_LOW:
                    begin
                        scl = 1'b1; load_delay(2); st = S_ACK_HIGH;
                    end
                    S_ACK_HIGH:
                    begin
                        scl = 1'b0; st = S_IDLE; fin = 1'b1;
                    end
                    S_WA_RELEASE:
                    begin
                        scl = 1'b1; load_delay(1); st = S_WA_RISE;
                    end
                    S_WA_RISE:
                    begin
                        poll_cnt = '0; st = S_WA_POLL;
                    end
                    default: st = S_IDLE;
                endcase
            end

            r.scl_out    = scl;
            r.sda_out    = sda_lvl;
            r.sda_enable = sda_en;
            r.busy_res   = (st != S_IDLE);
            r.done_res   = fin;
            r.read_value = rx_byte;
            r.ack_failed = ack_fail;
            want_lines.push_back(r);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_line(line_beat_t got);
            line_beat_t want;
            if (want_lines.size() == 0)
            begin
                errors++;
                $display("%0t: line beat expected none actual %p", $time, got);
                return;
            end
            want = want_lines.pop_front();
            field_check("scl_out", want.scl_out, got.scl_out);
            field_check("sda_out", want.sda_out, got.sda_out);
            field_check("sda_enable", want.sda_enable, got.sda_enable);
            field_check("busy_res", want.busy_res, got.busy_res);
            field_check("done_res", want.done_res, got.done_res);
            field_check("read_value", want.read_value, got.read_value);
            field_check("ack_failed", want.ack_failed, got.ack_failed);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    i2cm_tick_if tick_ch();
    i2cm_line_if line_ch();

    i2c_master_byte_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .line      (line_ch)
    );

    line_scoreboard sb;
    bit             quiet;      // no idling on either side
    bit             noise_on;   // stray commands while busy
    sda_style_t     sda_style;
    int             sda_hold;
    int             ticks_sent;
    line_beat_t     seen_beat;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Line sink: check every beat taken, stall now and then
    always @(posedge clk)
    begin
        if (line_ch.valid && line_ch.ready)
        begin
            seen_beat.scl_out    = line_ch.scl_out;
            seen_beat.sda_out    = line_ch.sda_out;
            seen_beat.sda_enable = line_ch.sda_enable;
            seen_beat.busy_res   = line_ch.busy_res;
            seen_beat.done_res   = line_ch.done_res;
            seen_beat.read_value = line_ch.read_value;
            seen_beat.ack_failed = line_ch.ack_failed;
            sb.check_line(seen_beat);
        end
        line_ch.ready <= quiet || ($urandom_range(99) >= 14);
    end

    // SDA seen by the engine: noise, or held high for a while and then low
    function logic sda_next();
        if (sda_style == SDA_NOISE)
            return 1'($urandom_range(1));
        if (sda_hold > 0)
        begin
            sda_hold--;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_tick(input tick_beat_t b);
        while (!quiet && $urandom_range(99) < 14)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.cmd_valid  <= b.cmd_valid;
        tick_ch.mode       <= b.mode;
        tick_ch.write_data <= b.write_data;
        tick_ch.send_ack   <= b.send_ack;
        tick_ch.sda_level  <= b.sda_level;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        sb.note_tick(b);
        ticks_sent++;
    endtask

    // Tick with no command the engine would take
    task automatic push_filler();
        tick_beat_t b;
        b.mode       = 3'($urandom_range(7));
        b.cmd_valid  = noise_on && ($urandom_range(3) == 0);
        if (sb.engine_idle() && b.mode <= MODE_WAIT_ACK)
            b.cmd_valid = 1'b0;
        b.write_data = 8'($urandom_range(255));
        b.send_ack   = 1'($urandom_range(1));
        b.sda_level  = sda_next();
        push_tick(b);
    endtask

    // Wait for the engine to go idle, then offer a command
    task automatic issue(input logic [2:0] mode, input logic [7:0] data, input logic ack,
                         input sda_style_t style, input int hold);
        tick_beat_t b;
        while (!sb.engine_idle()) push_filler();
        sda_style    = style;
        sda_hold     = hold;
        b.cmd_valid  = 1'b1;
        b.mode       = mode;
        b.write_data = data;
        b.send_ack   = ack;
        b.sda_level  = sda_next();
        push_tick(b);
    endtask

    // Mostly a quick ACK, sometimes long enough to time out
    task automatic issue_wait_ack();
        int hold;
        if ($urandom_range(9) < 7)
            hold = $urandom_range(6);
        else
            hold = $urandom_range(int'(sb.ack_limit) + 12);
        issue(MODE_WAIT_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              SDA_LOW_AFTER, hold);
    endtask

    // Start, address, ACK, one to three data bytes, stop
    task automatic run_transfer();
        bit rd;
        int n;
        rd = 1'($urandom_range(1));
        n  = $urandom_range(1, 3);
        issue(MODE_START, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_NOISE, 0);
        issue(MODE_WRITE, {7'($urandom_range(127)), rd}, 1'($urandom_range(1)), SDA_NOISE, 0);
        issue_wait_ack();
        for (int i = 0; i < n; i++)
        begin
            if (rd)
            begin
                issue(MODE_READ, 8'($urandom_range(255)),
                      (i != n - 1) ? 1'b1 : 1'($urandom_range(1)), SDA_NOISE, 0);
            end
            else
            begin
                issue(MODE_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      SDA_NOISE, 0);
                issue_wait_ack();
            end
        end
        issue(MODE_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_NOISE, 0);
    endtask

    task automatic run_random(input int budget);
        int first;
        first = ticks_sent;
        while (ticks_sent - first < budget)
        begin
            if ($urandom_range(9) == 0)
            begin
                // idle ticks and a stray command of any code
                repeat ($urandom_range(1, 3)) push_filler();
                issue(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                      SDA_NOISE, 0);
            end
            else
            begin
                run_transfer();
            end
        end
    endtask

    // Let the engine finish, stop sending and wait for every owed beat
    task automatic quiesce();
        while (!sb.engine_idle()) push_filler();
        tick_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Both registers; upper data bits of the timeout write are don't-care
    task automatic retune(input logic [9:0] t, input logic [9:0] lim_raw);
        quiesce();
        cfg_write <= 1'b1;
        cfg_index <= CFG_TICKS_PER_US;
        cfg_data  <= t;
        @(posedge clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data  <= lim_raw;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_config(t, lim_raw[7:0]);
    endtask

    initial
    begin
        logic [9:0] t;
        logic [7:0] lim;
        sb         = new();
        quiet      = 1'b0;
        noise_on   = 1'b0;
        sda_style  = SDA_NOISE;
        sda_hold   = 0;
        ticks_sent = 0;
        rst_n              <= 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= CFG_TICKS_PER_US;
        cfg_data           <= '0;
        tick_ch.valid      <= 1'b0;
        tick_ch.cmd_valid  <= 1'b0;
        tick_ch.mode       <= MODE_START;
        tick_ch.write_data <= '0;
        tick_ch.send_ack   <= 1'b0;
        tick_ch.sda_level  <= 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: a wait-ack on the reset tick rate
        issue(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_LOW_AFTER, 3);

        // zero tick rate and zero timeout, dropped codes, commands while busy
        retune(10'd0, {2'b10, 8'd0});
        noise_on = 1'b1;
        issue(MODE_START, 8'hFF, 1'b1, SDA_NOISE, 0);
        issue(MODE_WRITE, 8'h00, 1'b1, SDA_NOISE, 0);
        issue(MODE_WAIT_ACK, 8'hFF, 1'b1, SDA_LOW_AFTER, 1000);
        issue(MODE_READ, 8'h5A, 1'b0, SDA_NOISE, 0);
        issue(3'd5, 8'h00, 1'b0, SDA_NOISE, 0);
        issue(3'd6, 8'hFF, 1'b1, SDA_NOISE, 0);
        issue(3'd7, 8'h00, 1'b0, SDA_NOISE, 0);
        issue(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_LOW_AFTER, 0);
        issue(MODE_STOP, 8'hFF, 1'b1, SDA_NOISE, 0);

        // longest timeout, ACK never comes
        retune(10'd1, {2'b01, 8'd255});
        issue(MODE_START, 8'h00, 1'b0, SDA_NOISE, 0);
        issue(MODE_WAIT_ACK, 8'h00, 1'b0, SDA_LOW_AFTER, 5000);

        // random transfers on short timings
        for (int p = 0; p < 3; p++)
        begin
            case ($urandom_range(4))
                0:       t = 10'd0;
                1, 2:    t = 10'd1;
                3:       t = 10'd2;
                default: t = 10'd3;
            endcase
            case ($urandom_range(4))
                0:       lim = 8'd0;
                1:       lim = 8'd1;
                2:       lim = 8'($urandom_range(2, 12));
                3:       lim = 8'($urandom_range(13, 60));
                default: lim = 8'd255;
            endcase
            retune(t, {2'($urandom_range(3)), lim});
            quiet = (p == 1);
            run_random(150);
        end
        quiet = 1'b0;

        quiesce();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
